>>> hw/rtl/fvn_pkg.sv
// Shared constants and types for the fractal value noise block.
// No dependencies; compiled first.
package fvn_pkg;

	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
	localparam int CNT_W       = 4;
	localparam int AMP_W       = 17;
	localparam int VAL_W       = 24;
	localparam int TERM_W      = AMP_W + VAL_W;
	localparam int TOT_W       = TERM_W + $clog2(MAX_OCTAVES) + 1;
	localparam int NORM_W      = AMP_W + $clog2(MAX_OCTAVES) + 1;
	localparam int DIV_W       = NORM_W + 8;
	localparam int Q_W         = 16;

	localparam logic [31:0] HASH_X_MUL  = 32'h8DA6B343;
	localparam logic [31:0] HASH_Z_MUL  = 32'hD8163841;
	localparam logic [31:0] HASH_MUL_A  = 32'h2C1B3C6D;
	localparam logic [31:0] HASH_MUL_B  = 32'h297A2D39;
	localparam logic [31:0] SEED_STEP   = 32'h9E3779B9;
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [17:0] EASE_THREE  = 18'd196608;

	typedef enum logic [1:0] {
		REG_BASE_FREQ  = 2'd0,
		REG_OCT_COUNT  = 2'd1,
		REG_OCT_GAIN   = 2'd2,
		REG_NOISE_SEED = 2'd3
	} cfg_reg_t;

endpackage

>>> hw/rtl/fvn_if.sv
// Channel interfaces for the fractal value noise block: sample, result, configuration.
// Depends on fvn_pkg.
interface fvn_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;
	modport source (output valid, output pos_x, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_z, output ready);
endinterface

interface fvn_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;
	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

interface fvn_cfg_if;
	logic               valid;
	logic               ready;
	fvn_pkg::cfg_reg_t  index;
	logic [31:0]        data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/fractal_value_noise.sv
// Fractal value noise over a world position: one sample in, one normalised value out,
// at one transfer per clock unless an untaken result stalls. The octave lanes run side by
// side, each six stages deep, and the final division takes one stage per quotient bit in
// a 16-stage divider. Configuration is taken at any time but must be written while no
// sample is in flight; after a gain write the amplitude weights settle through amp_q.
// Depends on fvn_pkg, fvn_if, fvn_octave and fvn_div.
module fractal_value_noise (
	input  logic              clk,
	input  logic              arst_n,
	fvn_sample_if.sink        sample,
	fvn_result_if.source      result,
	fvn_cfg_if.sink           cfg
);

	localparam int N      = fvn_pkg::MAX_OCTAVES;
	localparam int STAGES = 10 + fvn_pkg::Q_W;

	logic [31:0]                base_freq_q;
	logic [fvn_pkg::CNT_W-1:0]  oct_count_q;
	logic [16:0]                oct_gain_q;
	logic [31:0]                noise_seed_q;

	logic [STAGES:1]            vld_q;
	logic                       en;

	logic signed [31:0]         px_s1, pz_s1;
	logic signed [63:0]         prod_x_s2, prod_z_s2;
	logic signed [65:0]         prod_x, prod_z;

	logic [31:0]                cx_s3 [0:N-1];
	logic [31:0]                cz_s3 [0:N-1];
	logic [15:0]                fx_s3 [0:N-1];
	logic [15:0]                fz_s3 [0:N-1];

	logic [fvn_pkg::AMP_W-1:0]  amp   [0:N-1];
	logic [fvn_pkg::AMP_W-1:0]  amp_q [1:N-1];
	logic [fvn_pkg::TERM_W-1:0] term  [0:N-1];
	logic [N-1:0]               active;
	logic [16:0]                gain;
	logic [fvn_pkg::OCT_W-1:0]  count;
	logic [fvn_pkg::NORM_W-1:0] norm_q, norm_sum;
	logic [fvn_pkg::TOT_W-1:0]  total_s10, total_sum;
	logic [fvn_pkg::Q_W-1:0]    quotient;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q  <= 32'd262144;
			oct_count_q  <= 4'd4;
			oct_gain_q   <= 17'd32768;
			noise_seed_q <= 32'd0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fvn_pkg::REG_BASE_FREQ:  base_freq_q  <= cfg.data;
				fvn_pkg::REG_OCT_COUNT:  oct_count_q  <= cfg.data[fvn_pkg::CNT_W-1:0];
				fvn_pkg::REG_OCT_GAIN:   oct_gain_q   <= cfg.data[16:0];
				fvn_pkg::REG_NOISE_SEED: noise_seed_q <= cfg.data;
			endcase
		end
	end

	// advance all stages together unless the result register holds an untaken value
	assign en           = !vld_q[STAGES] || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-1:1], sample.valid};
		end
	end

	assign prod_x = 66'(signed'({px_s1[31], px_s1})) * 66'(signed'({1'b0, base_freq_q}));
	assign prod_z = 66'(signed'({pz_s1[31], pz_s1})) * 66'(signed'({1'b0, base_freq_q}));

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1     <= sample.pos_x;
			pz_s1     <= sample.pos_z;
			prod_x_s2 <= prod_x[63:0];
			prod_z_s2 <= prod_z[63:0];
		end
	end

	assign gain = (oct_gain_q > fvn_pkg::ONE_Q16) ? fvn_pkg::ONE_Q16 : oct_gain_q;

	always_comb begin
		priority if (oct_count_q == '0) begin
			count = fvn_pkg::OCT_W'(1);
		end else if (32'(oct_count_q) > N) begin
			count = fvn_pkg::OCT_W'(N);
		end else begin
			count = fvn_pkg::OCT_W'(oct_count_q);
		end
	end

	assign amp[0] = fvn_pkg::ONE_Q16;

	for (genvar k = 0; k < N; k++) begin : g_lane
		logic signed [63:0] shx, shz;
		logic [31:0]        seed;
		if (k > 0) begin : g_amp
			logic [33:0] amp_p;
			assign amp_p  = 34'(amp[k-1]) * 34'(gain);
			assign amp[k] = amp_q[k];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					amp_q[k] <= '0;
				end else begin
					amp_q[k] <= fvn_pkg::AMP_W'(amp_p >> 16);
				end
			end
		end
		assign active[k] = 32'(count) > k;
		assign shx  = prod_x_s2 >>> (40 - k);
		assign shz  = prod_z_s2 >>> (40 - k);
		assign seed = noise_seed_q + 32'(k) * fvn_pkg::SEED_STEP;
		always_ff @(posedge clk) begin
			if (en) begin
				cx_s3[k] <= shx[31:0];
				cz_s3[k] <= shz[31:0];
				fx_s3[k] <= prod_x_s2[39-k:24-k];
				fz_s3[k] <= prod_z_s2[39-k:24-k];
			end
		end
		fvn_octave u_octave (
			.clk    (clk),
			.en     (en),
			.cx     (cx_s3[k]),
			.cz     (cz_s3[k]),
			.fx     (fx_s3[k]),
			.fz     (fz_s3[k]),
			.seed   (seed),
			.amp    (amp[k]),
			.active (active[k]),
			.term   (term[k])
		);
	end

	always_comb begin
		norm_sum  = '0;
		total_sum = '0;
		for (int k = 0; k < N; k++) begin
			norm_sum  = norm_sum + (active[k] ? fvn_pkg::NORM_W'(amp[k]) : '0);
			total_sum = total_sum + fvn_pkg::TOT_W'(term[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= '0;
		end else begin
			norm_q <= norm_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s10 <= total_sum;
		end
	end

	fvn_div u_div (
		.clk      (clk),
		.en       (en),
		.total    (total_s10),
		.divisor  ({norm_q, 8'd0}),
		.quotient (quotient)
	);

	assign result.valid       = vld_q[STAGES];
	assign result.noise_value = (base_freq_q == '0) ? '0 : quotient;

endmodule

>>> hw/rtl/fvn_octave.sv
// One octave lane: corner hashing, smoothstep, bilinear blend and amplitude weighting.
// Six pipeline stages (s4..s9). Depends on fvn_pkg.
module fvn_octave (
	input  logic                          clk,
	input  logic                          en,
	input  logic [31:0]                   cx,
	input  logic [31:0]                   cz,
	input  logic [15:0]                   fx,
	input  logic [15:0]                   fz,
	input  logic [31:0]                   seed,
	input  logic [fvn_pkg::AMP_W-1:0]     amp,
	input  logic                          active,
	output logic [fvn_pkg::TERM_W-1:0]    term
);

	logic [31:0] a_s4, b_s4;
	logic [15:0] fx_s4, fz_s4;
	logic [31:0] txx_s4, tzz_s4;
	logic [31:0] hm_s5 [0:3];
	logic [15:0] sx_s5, sz_s5;
	logic [31:0] hn_s6 [0:3];
	logic [15:0] sx_s6, sz_s6;
	logic [23:0] top_s7, bot_s7;
	logic [15:0] sz_s7;
	logic [23:0] noise_s8;
	logic [fvn_pkg::TERM_W-1:0] term_s9;

	logic [47:0] ex_p, ez_p;
	logic [31:0] h5 [0:3];
	logic [31:0] h6 [0:3];
	logic [23:0] v7 [0:3];
	logic [16:0] sxc7, szc8;
	logic [41:0] top_sum, bot_sum, mix_sum;

	assign ex_p = 48'(txx_s4) * 48'(fvn_pkg::EASE_THREE - {1'b0, fx_s4, 1'b0});
	assign ez_p = 48'(tzz_s4) * 48'(fvn_pkg::EASE_THREE - {1'b0, fz_s4, 1'b0});

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			h5[j] = seed
				^ (a_s4 + ((j % 2) == 1 ? fvn_pkg::HASH_X_MUL : 32'd0))
				^ (b_s4 + ((j / 2) == 1 ? fvn_pkg::HASH_Z_MUL : 32'd0));
			h5[j] = h5[j] ^ (h5[j] >> 15);
			h6[j] = hm_s5[j] ^ (hm_s5[j] >> 12);
			v7[j] = 24'((hn_s6[j] ^ (hn_s6[j] >> 15)) >> 8);
		end
	end

	assign sxc7    = fvn_pkg::ONE_Q16 - {1'b0, sx_s6};
	assign szc8    = fvn_pkg::ONE_Q16 - {1'b0, sz_s7};
	assign top_sum = 42'(v7[0]) * 42'(sxc7) + 42'(v7[1]) * 42'(sx_s6);
	assign bot_sum = 42'(v7[2]) * 42'(sxc7) + 42'(v7[3]) * 42'(sx_s6);
	assign mix_sum = 42'(top_s7) * 42'(szc8) + 42'(bot_s7) * 42'(sz_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= cx * fvn_pkg::HASH_X_MUL;
			b_s4   <= cz * fvn_pkg::HASH_Z_MUL;
			fx_s4  <= fx;
			fz_s4  <= fz;
			txx_s4 <= 32'(fx) * 32'(fx);
			tzz_s4 <= 32'(fz) * 32'(fz);
			for (int j = 0; j < 4; j++) begin
				hm_s5[j] <= h5[j] * fvn_pkg::HASH_MUL_A;
				hn_s6[j] <= h6[j] * fvn_pkg::HASH_MUL_B;
			end
			sx_s5    <= ex_p[47:32];
			sz_s5    <= ez_p[47:32];
			sx_s6    <= sx_s5;
			sz_s6    <= sz_s5;
			top_s7   <= top_sum[39:16];
			bot_s7   <= bot_sum[39:16];
			sz_s7    <= sz_s6;
			noise_s8 <= mix_sum[39:16];
			term_s9  <= active ? fvn_pkg::TERM_W'(amp) * fvn_pkg::TERM_W'(noise_s8) : '0;
		end
	end

	assign term = term_s9;

endmodule

>>> hw/rtl/fvn_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the final normalisation.
// Depends on fvn_pkg.
module fvn_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fvn_pkg::TOT_W-1:0]   total,
	input  logic [fvn_pkg::DIV_W-1:0]   divisor,
	output logic [fvn_pkg::Q_W-1:0]     quotient
);

	logic [fvn_pkg::TOT_W-1:0] rem_s [1:fvn_pkg::Q_W];
	logic [fvn_pkg::Q_W-1:0]   q_s   [1:fvn_pkg::Q_W];

	for (genvar g = 0; g < fvn_pkg::Q_W; g++) begin : g_stage
		localparam int B = fvn_pkg::Q_W - 1 - g;
		logic [fvn_pkg::TOT_W-1:0] r_in, dsh;
		logic [fvn_pkg::Q_W-1:0]   q_in;
		logic                      ge;
		if (g == 0) begin : g_first
			assign r_in = total;
			assign q_in = '0;
		end else begin : g_rest
			assign r_in = rem_s[g];
			assign q_in = q_s[g];
		end
		assign dsh = fvn_pkg::TOT_W'(divisor) << B;
		assign ge  = r_in >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? r_in - dsh : r_in;
				q_s[g+1]   <= {q_in[fvn_pkg::Q_W-2:0], ge};
			end
		end
	end

	assign quotient = q_s[fvn_pkg::Q_W];

endmodule
